@@ hdl/kvt_pkg.sv @@
// Shared constants, word types and helpers for the keyed value table.
package kvt_pkg;

    localparam int ENTRIES   = 64;
    localparam int LIFE_BITS = 16;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int LIFE_IN_W = 16;
    localparam int CNT_OUT_W = 7;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WALK_W    = $clog2(ENTRIES + 1);

    // operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_SET    = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_LOOKUP = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_TICK   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]                  mode;
        logic [KEY_W-1:0]            key;
        logic signed [VAL_W-1:0]     value;
        logic [LIFE_IN_W-1:0]        lifetime;
    } t_in_word;

    typedef struct packed {
        logic                        found;
        logic signed [VAL_W-1:0]     stored_value;
        logic [CNT_OUT_W-1:0]        removed_count;
        logic                        status;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // saturate a requested lifetime to the stored width
    function automatic logic [LIFE_BITS-1:0] fit_life(input logic [LIFE_IN_W-1:0] life);
        logic [32:0] ext;
        logic [32:0] mask;
        ext  = 33'(life);
        mask = 33'((64'd1 << LIFE_BITS) - 64'd1);
        return (ext > mask) ? mask[LIFE_BITS-1:0] : ext[LIFE_BITS-1:0];
    endfunction

endpackage

@@ hdl/kvt_if.sv @@
// Valid/ready channel interfaces for the request and result words.
interface kvt_in_if import kvt_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kvt_out_if import kvt_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/kvt_ctrl.sv @@
// Sequencer that accepts a word, walks the table and triggers the finish step.
module kvt_ctrl import kvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [WALK_W-1:0] r_cnt, n_cnt;

    // next state and walk counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + WALK_W'(1);
                if (r_cnt == WALK_W'(ENTRIES)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // drive datapath commands
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.rd_en  = (r_state == ST_SWEEP) && (r_cnt < WALK_W'(ENTRIES));
    assign o_cmd.rd_idx = r_cnt[IDX_W-1:0];
    assign o_cmd.finish = (r_state == ST_FINISH) && i_sts.out_free;

endmodule

@@ hdl/kvt_dp.sv @@
// Table storage, search and aging datapath, and the result register.
module kvt_dp import kvt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // table memories and per-entry valid flags
    logic [KEY_W-1:0]     r_key_mem  [ENTRIES];
    logic [VAL_W-1:0]     r_val_mem  [ENTRIES];
    logic [LIFE_BITS-1:0] r_life_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;

    // captured request
    logic [2:0]           r_mode;
    logic [KEY_W-1:0]     r_key;
    logic [VAL_W-1:0]     r_value;
    logic [LIFE_BITS-1:0] r_life;

    // registered read port
    logic [KEY_W-1:0]     r_key_q;
    logic [VAL_W-1:0]     r_val_q;
    logic [LIFE_BITS-1:0] r_life_q;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;

    // search and aging results
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [VAL_W-1:0]     r_hit_val;
    logic                 r_free_ok;
    logic [IDX_W-1:0]     r_free_idx;
    logic [CNT_OUT_W-1:0] r_count;

    // result register
    logic                 r_out_vld;
    t_out_word            r_out;

    // memory write port
    logic                 we_key, we_val, we_life;
    logic [IDX_W-1:0]     wr_idx;
    logic [VAL_W-1:0]     wr_val;
    logic [LIFE_BITS-1:0] wr_life;

    logic                 is_key_op, is_tick, ent_valid, age_hit, age_expire;
    logic [VAL_W-1:0]     new_val;
    t_out_word            n_out;
    logic                 set_valid, clr_valid;
    logic [IDX_W-1:0]     set_idx, clr_idx;

    assign is_key_op  = (r_mode == MODE_SET) || (r_mode == MODE_ADD) ||
                        (r_mode == MODE_LOOKUP) || (r_mode == MODE_REMOVE);
    assign is_tick    = (r_mode == MODE_TICK);
    assign ent_valid  = r_valid[r_rd_idx];
    assign age_hit    = r_rd_vld && is_tick && ent_valid && (r_life_q != '0);
    assign age_expire = age_hit && (r_life_q == LIFE_BITS'(1));
    assign new_val    = (r_mode == MODE_ADD) ? (r_value + r_hit_val) : r_value;

    // finish step: pick writes and build the result word
    always_comb begin
        we_key    = 1'b0;
        we_val    = 1'b0;
        we_life   = 1'b0;
        wr_idx    = r_rd_idx;
        wr_val    = new_val;
        wr_life   = r_life;
        set_valid = 1'b0;
        set_idx   = r_free_idx;
        clr_valid = 1'b0;
        clr_idx   = r_rd_idx;
        n_out     = '0;
        if (age_hit) begin
            we_life   = 1'b1;
            wr_life   = r_life_q - LIFE_BITS'(1);
            clr_valid = age_expire;
        end
        if (i_cmd.finish) begin
            case (r_mode)
                MODE_SET, MODE_ADD: begin
                    if (r_hit) begin
                        we_val             = 1'b1;
                        we_life            = 1'b1;
                        wr_idx             = r_hit_idx;
                        n_out.found        = 1'b1;
                        n_out.stored_value = new_val;
                    end else if (r_free_ok) begin
                        we_key             = 1'b1;
                        we_val             = 1'b1;
                        we_life            = 1'b1;
                        wr_idx             = r_free_idx;
                        wr_val             = r_value;
                        set_valid          = 1'b1;
                        n_out.stored_value = r_value;
                    end else begin
                        n_out.status = 1'b1;
                    end
                end
                MODE_LOOKUP: begin
                    n_out.found        = r_hit;
                    n_out.stored_value = r_hit ? r_hit_val : '0;
                end
                MODE_REMOVE: begin
                    if (r_hit) begin
                        clr_valid           = 1'b1;
                        clr_idx             = r_hit_idx;
                        n_out.found         = 1'b1;
                        n_out.removed_count = CNT_OUT_W'(1);
                    end
                end
                MODE_TICK: begin
                    n_out.removed_count = r_count;
                end
                default: begin
                    n_out = '0;
                end
            endcase
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (we_key) begin
            r_key_mem[wr_idx] <= r_key;
        end
        if (we_val) begin
            r_val_mem[wr_idx] <= wr_val;
        end
        if (we_life) begin
            r_life_mem[wr_idx] <= wr_life;
        end
        if (i_cmd.rd_en) begin
            r_key_q  <= r_key_mem[i_cmd.rd_idx];
            r_val_q  <= r_val_mem[i_cmd.rd_idx];
            r_life_q <= r_life_mem[i_cmd.rd_idx];
        end
    end

    // valid flags and read pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (clr_valid) begin
                r_valid[clr_idx] <= 1'b0;
            end
            if (set_valid) begin
                r_valid[set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_idx;
    end

    // capture request, then track first match, first free slot, expiries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_count   <= '0;
        end else if (i_cmd.load) begin
            r_mode    <= i_word.mode;
            r_key     <= i_word.key;
            r_value   <= i_word.value;
            r_life    <= fit_life(i_word.lifetime);
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_count   <= '0;
        end else if (r_rd_vld) begin
            if (is_key_op && ent_valid && (r_key_q == r_key) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_val <= r_val_q;
            end
            if (!ent_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (age_expire && (r_count != {CNT_OUT_W{1'b1}})) begin
                r_count <= r_count + CNT_OUT_W'(1);
            end
        end
    end

    // hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_word     = r_out;

endmodule

@@ hdl/keyed_value_table_with_aging_top.sv @@
// Top level of the keyed value table with lifetime aging.
// Every request word (set, add, lookup, remove or tick) walks the whole table. After the
// accepting edge, the sweep state reads every slot through the single registered read port
// of the table memory, and then the finish step applies the write and loads the result register.
// The next word is taken in the cycle after that apply step. A new word is taken only after the
// previous one has been applied, and its result may still wait in the output register. The apply
// step waits while an earlier result is still unread, so a stalled receiver adds its stall cycles.
// Valid flags are flip-flops cleared by reset, so no clearing pass follows reset.
module keyed_value_table_with_aging_top import kvt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kvt_in_if.sink    i_in,
    kvt_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kvt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_word  (o_out.data)
    );

    assign i_in.ready = in_ready;

endmodule

@@ hdl/kvt_checker.sv @@
// Port-level checker for the keyed value table, bound to the top level.
module kvt_checker import kvt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_word
);

    // a word is worked on through a full table walk, so ready drops right after accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready high right after accept");

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_word)))
        else $error("result dropped or changed while stalled");

    // a dropped insert reports nothing else
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_word.status) |->
        (!i_out_word.found && (i_out_word.stored_value == '0) &&
         (i_out_word.removed_count == '0)))
        else $error("full flag with other fields set");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind keyed_value_table_with_aging_top kvt_checker u_kvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);
